### rtl/idll_pkg.sv
`default_nettype none

package idll_pkg;

    // pool geometry: slots 0..POOL_NODES-1 live in memory, the root in registers
    localparam int unsigned POOL_NODES = 1024;
    localparam int unsigned IDX_W      = 11;
    localparam int unsigned ADDR_W     = $clog2(POOL_NODES);
    localparam logic [IDX_W-1:0]  ROOT_IDX = IDX_W'(POOL_NODES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_NODES - 1);

    // stream widths
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 32;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ADD_HEAD  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_TAIL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOVE_HEAD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MOVE_TAIL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PROBE     = 3'd5;

    // link edit steps: unlink is 0..2, link-in is 3..5
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_UNLINK_PREV = 3'd0;
    localparam logic [STEP_W-1:0] STEP_UNLINK_NEXT = 3'd1;
    localparam logic [STEP_W-1:0] STEP_UNLINK_SELF = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LINK_AFTER  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LINK_NODE   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LINK_BEFORE = 3'd5;

    // one memory word holds both links of a slot
    typedef struct packed {
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] next;
    } t_link;

    localparam int unsigned LINK_W = $bits(t_link);

    // which part of a link word one step rewrites
    typedef enum logic [1:0] {
        FLD_PREV,
        FLD_NEXT,
        FLD_BOTH
    } t_field;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_OP_RD,
        ST_OP_WR,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

### rtl/indexed_doubly_linked_list_engine_core.sv
`default_nettype none

// Channel   Dir  Beat fields (lowest bit first)
// s_axis    in   tuser: kind[2:0]; tdata: node_index[10:0], zero pad to 16
// m_axis    out  tdata: applied, node_linked, list_empty, head_index[10:0],
//                       tail_index[10:0], zero pad to 32
//
// One request at a time; each link edit is a read and a write-back on the
// single-port link memory (the root's links sit in registers). A request for
// the root or a higher index is refused at once; any other is decided from
// the node's links, then its edit steps run, then the result beat. After reset
// a clearing pass writes every slot's links to itself with s_axis_tready low.
// A stalled m_axis holds the result beat and keeps s_axis_tready low.

module indexed_doubly_linked_list_engine_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [idll_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // node_index
    input  wire logic [idll_pkg::KIND_W-1:0]         s_axis_tuser,  // kind
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [idll_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // see table
);

    idll_pkg::t_state              r_state, n_state;
    logic [idll_pkg::ADDR_W-1:0]   r_clr;
    logic [idll_pkg::KIND_W-1:0]   r_kind;
    logic [idll_pkg::IDX_W-1:0]    r_node, r_p, r_q, r_a, r_b;
    logic [idll_pkg::IDX_W-1:0]    r_head, r_tail;
    logic [idll_pkg::STEP_W-1:0]   r_step, r_last;
    logic                          r_applied, r_linked;

    logic                          mem_we;
    logic [idll_pkg::ADDR_W-1:0]   mem_addr;
    idll_pkg::t_link               mem_wdata, mem_rdata;

    logic [idll_pkg::IDX_W-1:0]    in_node;
    logic                          in_accept, out_accept, in_range;
    logic                          self_loop, in_list, go;
    logic [idll_pkg::STEP_W-1:0]   start_step, last_step;
    logic                          step_done, enter_link;
    logic                          to_head;

    idll_pkg::t_field              op_sel;
    logic [idll_pkg::IDX_W-1:0]    op_addr, op_val;
    idll_pkg::t_link               op_word;
    logic                          op_root;

    idll_ram #(
        .WIDTH (idll_pkg::LINK_W),
        .DEPTH (idll_pkg::POOL_NODES)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // handshakes
    assign in_node    = s_axis_tdata[idll_pkg::IDX_W-1:0];
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign out_accept = m_axis_tvalid && m_axis_tready;
    assign in_range   = in_node < idll_pkg::ROOT_IDX;

    // guards, from the node's links as read
    assign self_loop = (mem_rdata.prev == r_node) && (mem_rdata.next == r_node);
    assign in_list   = (mem_rdata.prev != r_node) && (mem_rdata.next != r_node);

    always_comb begin
        go         = 1'b0;
        start_step = idll_pkg::STEP_UNLINK_PREV;
        last_step  = idll_pkg::STEP_LINK_BEFORE;
        case (r_kind)
            idll_pkg::KIND_ADD_HEAD: begin
                go         = self_loop && (mem_rdata.prev != idll_pkg::ROOT_IDX);
                start_step = idll_pkg::STEP_LINK_AFTER;
            end
            idll_pkg::KIND_ADD_TAIL: begin
                go         = self_loop && (mem_rdata.next != idll_pkg::ROOT_IDX);
                start_step = idll_pkg::STEP_LINK_AFTER;
            end
            idll_pkg::KIND_MOVE_HEAD: begin
                go = in_list && (mem_rdata.prev != mem_rdata.next)
                     && (mem_rdata.prev != idll_pkg::ROOT_IDX);
            end
            idll_pkg::KIND_MOVE_TAIL: begin
                go = in_list && (mem_rdata.prev != mem_rdata.next)
                     && (mem_rdata.next != idll_pkg::ROOT_IDX);
            end
            idll_pkg::KIND_REMOVE: begin
                go        = in_list;
                last_step = idll_pkg::STEP_UNLINK_SELF;
            end
            default: begin
                go = 1'b0;
            end
        endcase
    end

    // current link edit: target slot, field and value
    always_comb begin
        op_addr = r_node;
        op_sel  = idll_pkg::FLD_BOTH;
        op_val  = r_node;
        op_word = '{prev: r_node, next: r_node};
        case (r_step)
            idll_pkg::STEP_UNLINK_PREV: begin
                op_addr = r_q;
                op_sel  = idll_pkg::FLD_PREV;
                op_val  = r_p;
            end
            idll_pkg::STEP_UNLINK_NEXT: begin
                op_addr = r_p;
                op_sel  = idll_pkg::FLD_NEXT;
                op_val  = r_q;
            end
            idll_pkg::STEP_UNLINK_SELF: begin
                op_sel = idll_pkg::FLD_BOTH;
            end
            idll_pkg::STEP_LINK_AFTER: begin
                op_addr = r_a;
                op_sel  = idll_pkg::FLD_PREV;
            end
            idll_pkg::STEP_LINK_NODE: begin
                op_word = '{prev: r_b, next: r_a};
            end
            idll_pkg::STEP_LINK_BEFORE: begin
                op_addr = r_b;
                op_sel  = idll_pkg::FLD_NEXT;
            end
            default: begin
                op_sel = idll_pkg::FLD_BOTH;
            end
        endcase
    end

    assign op_root    = op_addr == idll_pkg::ROOT_IDX;
    assign step_done  = r_step == r_last;
    assign enter_link = (r_state == idll_pkg::ST_OP_WR) && !step_done
                        && (r_step == idll_pkg::STEP_UNLINK_SELF);
    assign to_head    = (r_kind == idll_pkg::KIND_ADD_HEAD)
                        || (r_kind == idll_pkg::KIND_MOVE_HEAD);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            idll_pkg::ST_CLEAR: begin
                if (r_clr == idll_pkg::LAST_ADDR) begin
                    n_state = idll_pkg::ST_IDLE;
                end
            end
            idll_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = in_range ? idll_pkg::ST_DECIDE : idll_pkg::ST_RESULT;
                end
            end
            idll_pkg::ST_DECIDE: begin
                n_state = go ? idll_pkg::ST_OP_RD : idll_pkg::ST_RESULT;
            end
            idll_pkg::ST_OP_RD: begin
                n_state = idll_pkg::ST_OP_WR;
            end
            idll_pkg::ST_OP_WR: begin
                n_state = step_done ? idll_pkg::ST_RESULT : idll_pkg::ST_OP_RD;
            end
            idll_pkg::ST_RESULT: begin
                if (out_accept) begin
                    n_state = idll_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = idll_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and memory port
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mem_we        = 1'b0;
        mem_addr      = r_node[idll_pkg::ADDR_W-1:0];
        mem_wdata     = op_word;
        case (r_state)
            idll_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '{prev: idll_pkg::IDX_W'(r_clr), next: idll_pkg::IDX_W'(r_clr)};
            end
            idll_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                mem_addr      = in_node[idll_pkg::ADDR_W-1:0];
            end
            idll_pkg::ST_OP_RD: begin
                mem_addr = op_addr[idll_pkg::ADDR_W-1:0];
            end
            idll_pkg::ST_OP_WR: begin
                mem_we   = !op_root;
                mem_addr = op_addr[idll_pkg::ADDR_W-1:0];
                case (op_sel)
                    idll_pkg::FLD_PREV: mem_wdata = '{prev: op_val, next: mem_rdata.next};
                    idll_pkg::FLD_NEXT: mem_wdata = '{prev: mem_rdata.prev, next: op_val};
                    default:            mem_wdata = op_word;
                endcase
            end
            idll_pkg::ST_RESULT: begin
                m_axis_tvalid = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign m_axis_tdata = {
        {(idll_pkg::OUT_DATA_W - 3 - 2 * idll_pkg::IDX_W){1'b0}},
        r_tail, r_head, (r_head == idll_pkg::ROOT_IDX), r_linked, r_applied
    };

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idll_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_head  <= idll_pkg::ROOT_IDX;
            r_tail  <= idll_pkg::ROOT_IDX;
        end else begin
            r_state <= n_state;
            if (r_state == idll_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // root links live here, not in memory
            if ((r_state == idll_pkg::ST_OP_WR) && op_root) begin
                if (op_sel == idll_pkg::FLD_PREV) begin
                    r_tail <= op_val;
                end else if (op_sel == idll_pkg::FLD_NEXT) begin
                    r_head <= op_val;
                end
            end
        end
    end

    // request payload and step bookkeeping
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind    <= s_axis_tuser;
            r_node    <= in_node;
            r_applied <= 1'b0;
            r_linked  <= 1'b0;
        end
        if (r_state == idll_pkg::ST_DECIDE) begin
            r_p       <= mem_rdata.prev;
            r_q       <= mem_rdata.next;
            r_step    <= start_step;
            r_last    <= last_step;
            r_applied <= go;
            r_linked  <= go ? (r_kind != idll_pkg::KIND_REMOVE) : (mem_rdata.next != r_node);
        end
        if ((r_state == idll_pkg::ST_OP_WR) && !step_done) begin
            r_step <= r_step + 1'b1;
        end
        // insertion neighbors, taken from the root as it stands when link-in starts
        if (((r_state == idll_pkg::ST_DECIDE) && (start_step == idll_pkg::STEP_LINK_AFTER))
            || enter_link) begin
            r_b <= to_head ? idll_pkg::ROOT_IDX : r_tail;
            r_a <= to_head ? r_head : idll_pkg::ROOT_IDX;
        end
    end

`ifndef SYNTHESIS
    // head and tail agree on emptiness between requests
    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == idll_pkg::ST_IDLE)
        |-> ((r_head == idll_pkg::ROOT_IDX) == (r_tail == idll_pkg::ROOT_IDX)))
        else $error("root head and tail disagree on empty list");

    // an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("ready stayed high after accept");

    // an applied remove leaves the node unlinked; an applied add or move links it
    a_linked_matches_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_applied) |-> (r_linked == (r_kind != idll_pkg::KIND_REMOVE)))
        else $error("node_linked wrong for applied request");

    // link edit steps stay within the sequence
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == idll_pkg::ST_OP_RD) || (r_state == idll_pkg::ST_OP_WR))
        |-> ((r_step <= idll_pkg::STEP_LINK_BEFORE) && (r_step <= r_last)))
        else $error("link edit step out of range");
`endif

endmodule

`default_nettype wire

### rtl/idll_ram.sv
`default_nettype none

module idll_ram #(
    parameter int unsigned WIDTH = 22,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire
